>>> design/gpnm_pkg.sv
// ----------------------------------------------------------------------------
// gpnm_pkg
// Widths, operation and label codes, and the pitch store write bundle shared
// by the greedy pitch note matcher modules.
// ----------------------------------------------------------------------------
package gpnm_pkg;

    localparam int PITCH_W    = 7;
    localparam int PIDX_W     = 6;
    localparam int CNT_W      = 7;
    localparam int SIDX_W     = 16;
    localparam int OP_W       = 2;
    localparam int LBL_W      = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SCORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [LBL_W-1:0] LBL_MATCH     = 2'd0;
    localparam logic [LBL_W-1:0] LBL_DELETION  = 2'd1;
    localparam logic [LBL_W-1:0] LBL_INSERTION = 2'd2;
    localparam logic [LBL_W-1:0] LBL_END       = 2'd3;

    typedef struct packed {
        logic               en;
        logic [PIDX_W-1:0]  addr;
        logic [PITCH_W-1:0] data;
    } t_store_wr;

endpackage

>>> design/gpnm_pitch_store.sv
// ----------------------------------------------------------------------------
// gpnm_pitch_store
// Performance pitch memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module gpnm_pitch_store
    import gpnm_pkg::*;
#(
    parameter int MAX_PERF_NOTES = 64
) (
    input  logic               i_clk,
    input  t_store_wr          i_wr,
    input  logic [PIDX_W-1:0]  i_rd_addr,
    output logic [PITCH_W-1:0] o_rd_pitch
);

    logic [PITCH_W-1:0] r_mem [MAX_PERF_NOTES];
    logic [PITCH_W-1:0] r_rd_pitch;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_pitch <= r_mem[i_rd_addr];
    end

    assign o_rd_pitch = r_rd_pitch;

endmodule

>>> design/greedy_pitch_note_matcher.sv
// ----------------------------------------------------------------------------
// greedy_pitch_note_matcher
// Greedy note aligner: score notes claim the first unused performance note of
// equal pitch; a finish item lists the unused performance notes.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser carries the operation (load, score, finish),
// tdata the pitch. Output stream m_axis: tuser carries the label, tdata the
// score index, performance index and overflow flag, tlast the final result
// of an item.
// A load gives no result. A score note walks the pitch store through one
// comparator, one entry per cycle; its result waits in the emit state until
// the output register is free. A finish walks the used flags one per cycle
// while the receiver keeps up and gives one result per unused entry (or one
// end marker). s_axis_tready is high only between items.
// The output register holds a result until it is taken; the next item is
// accepted while it waits, and the sequencer stalls only when it has a new
// result to place. Reset clears the used flags, the note count, the score
// counter and the overflow flag; the pitch store is not cleared.
// ----------------------------------------------------------------------------
module greedy_pitch_note_matcher
    import gpnm_pkg::*;
#(
    parameter int MAX_PERF_NOTES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [6:0] pitch
    input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] score_index,
                                                  // [21:16] perf_index,
                                                  // [22] overflow
    output logic [LBL_W-1:0]      m_axis_tuser,   // [1:0] label
    output logic                  m_axis_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_PERF_NOTES);

    logic [1:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [SIDX_W-1:0]         r_score, n_score;
    logic                      r_ovf, n_ovf;
    logic [MAX_PERF_NOTES-1:0] r_used, n_used;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic                      r_rd_vld, n_rd_vld;
    logic [PIDX_W-1:0]         r_rd_idx, n_rd_idx;
    logic                      r_pend_vld, n_pend_vld;
    logic [PIDX_W-1:0]         r_pend, n_pend;
    logic [PITCH_W-1:0]        r_pitch, n_pitch;
    logic [LBL_W-1:0]          r_res_lbl, n_res_lbl;
    logic [SIDX_W-1:0]         r_res_sidx, n_res_sidx;
    logic [PIDX_W-1:0]         r_res_pidx, n_res_pidx;
    logic                      r_out_vld, n_out_vld;
    logic [LBL_W-1:0]          r_out_lbl, n_out_lbl;
    logic [SIDX_W-1:0]         r_out_sidx, n_out_sidx;
    logic [PIDX_W-1:0]         r_out_pidx, n_out_pidx;
    logic                      r_out_ovf, n_out_ovf;
    logic                      r_out_last, n_out_last;

    t_store_wr          store_wr;
    logic [PITCH_W-1:0] rd_pitch;
    logic               in_xfer;
    logic               slot_free;
    logic               hit;

    gpnm_pitch_store #(
        .MAX_PERF_NOTES (MAX_PERF_NOTES)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr       (store_wr),
        .i_rd_addr  (r_idx[PIDX_W-1:0]),
        .o_rd_pitch (rd_pitch)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_vld || m_axis_tready;
    assign hit           = r_rd_vld && !r_used[r_rd_idx] && (rd_pitch == r_pitch);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_score    = r_score;
        n_ovf      = r_ovf;
        n_used     = r_used;
        n_idx      = r_idx;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_pitch    = r_pitch;
        n_res_lbl  = r_res_lbl;
        n_res_sidx = r_res_sidx;
        n_res_pidx = r_res_pidx;
        n_out_vld  = r_out_vld;
        n_out_lbl  = r_out_lbl;
        n_out_sidx = r_out_sidx;
        n_out_pidx = r_out_pidx;
        n_out_ovf  = r_out_ovf;
        n_out_last = r_out_last;
        store_wr   = '0;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                n_rd_idx = '0;
                if (in_xfer) begin
                    case (s_axis_tuser)
                        OP_LOAD: begin
                            if (r_cnt < CAP) begin
                                store_wr.en   = 1'b1;
                                store_wr.addr = r_cnt[PIDX_W-1:0];
                                store_wr.data = s_axis_tdata[PITCH_W-1:0];
                                n_used[r_cnt[PIDX_W-1:0]] = 1'b0;
                                n_cnt = r_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_SCORE: begin
                            n_pitch    = s_axis_tdata[PITCH_W-1:0];
                            n_res_sidx = r_score;
                            if (r_score != '1) begin
                                n_score = r_score + SIDX_W'(1);
                            end
                            n_idx    = CNT_W'(1);
                            n_rd_vld = (r_cnt != '0);
                            n_state  = ST_SCAN;
                        end
                        OP_FINISH: begin
                            n_pend_vld = 1'b0;
                            n_idx      = '0;
                            n_state    = ST_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                n_rd_vld = (r_idx < r_cnt);
                n_rd_idx = r_idx[PIDX_W-1:0];
                n_idx    = r_idx + CNT_W'(1);
                if (hit) begin
                    n_used[r_rd_idx] = 1'b1;
                    n_res_lbl  = LBL_MATCH;
                    n_res_pidx = r_rd_idx;
                    n_idx      = '0;
                    n_rd_vld   = 1'b0;
                    n_state    = ST_EMIT;
                end else if (!r_rd_vld) begin
                    n_res_lbl  = LBL_DELETION;
                    n_res_pidx = '0;
                    n_idx      = '0;
                    n_rd_vld   = 1'b0;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_lbl  = r_res_lbl;
                    n_out_sidx = r_res_sidx;
                    n_out_pidx = r_res_pidx;
                    n_out_ovf  = r_ovf;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (r_idx < r_cnt) begin
                    if (!r_used[r_idx[PIDX_W-1:0]]) begin
                        if (!r_pend_vld) begin
                            n_pend_vld = 1'b1;
                            n_pend     = r_idx[PIDX_W-1:0];
                            n_idx      = r_idx + CNT_W'(1);
                        end else if (slot_free) begin
                            n_out_vld  = 1'b1;
                            n_out_lbl  = LBL_INSERTION;
                            n_out_sidx = '0;
                            n_out_pidx = r_pend;
                            n_out_ovf  = r_ovf;
                            n_out_last = 1'b0;
                            n_pend     = r_idx[PIDX_W-1:0];
                            n_idx      = r_idx + CNT_W'(1);
                        end
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end else if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_lbl  = r_pend_vld ? LBL_INSERTION : LBL_END;
                    n_out_sidx = '0;
                    n_out_pidx = r_pend_vld ? r_pend : '0;
                    n_out_ovf  = r_ovf;
                    n_out_last = 1'b1;
                    n_used     = '0;
                    n_cnt      = '0;
                    n_score    = '0;
                    n_ovf      = 1'b0;
                    n_pend_vld = 1'b0;
                    n_idx      = '0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_score    <= '0;
            r_ovf      <= 1'b0;
            r_used     <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_score    <= n_score;
            r_ovf      <= n_ovf;
            r_used     <= n_used;
            r_idx      <= n_idx;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_pend     <= n_pend;
        r_pitch    <= n_pitch;
        r_res_lbl  <= n_res_lbl;
        r_res_sidx <= n_res_sidx;
        r_res_pidx <= n_res_pidx;
        r_out_lbl  <= n_out_lbl;
        r_out_sidx <= n_out_sidx;
        r_out_pidx <= n_out_pidx;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_ovf, r_out_pidx, r_out_sidx};
    assign m_axis_tuser  = r_out_lbl;
    assign m_axis_tlast  = r_out_last;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP)
        else $error("note count beyond capacity");

    a_match_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_lbl == LBL_MATCH) |-> r_used[r_out_pidx])
        else $error("matched note not marked used");

    a_score_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == OP_SCORE) |=> (r_state == ST_SCAN))
        else $error("score note did not start a scan");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("store read pending outside a scan");

    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && n_state == ST_IDLE)
        |=> (r_cnt == '0 && r_score == '0 && !r_ovf && r_used == '0))
        else $error("finish left state behind");

endmodule
